>>> rtl/gzhs_pkg.sv
// Shared types for the gzip header stripper: result kinds, result beats and queue entries.
package gzhs_pkg;

    // Kind of one result beat.
    typedef enum logic [2:0] {
        KIND_HEADER  = 3'd0,
        KIND_PAYLOAD = 3'd1,
        KIND_BAD     = 3'd2,
        KIND_TRUNC   = 3'd3,
        KIND_END     = 3'd4
    } kind_t;

    // One result beat as it leaves the block.
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  payload_byte;
        logic        wrapped;
        logic        last;
    } result_t;

    // One classified input byte: one or two result beats.
    typedef struct packed {
        logic    two;
        result_t first;
        result_t second;
    } cmd_t;

endpackage

>>> rtl/gzhs_in_if.sv
// Byte stream channel into the gzip header stripper.
interface gzhs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_stream;

    modport source (output valid, output data_byte, output end_of_stream, input ready);
    modport sink (input valid, input data_byte, input end_of_stream, output ready);
endinterface

>>> rtl/gzhs_out_if.sv
// Result channel out of the gzip header stripper.
interface gzhs_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] payload_byte;
    logic       wrapped;
    logic       last;

    modport source (output valid, output kind, output payload_byte, output wrapped,
                    output last, input ready);
    modport sink (input valid, input kind, input payload_byte, input wrapped,
                  input last, output ready);
endinterface

>>> rtl/gzhs_front.sv
// Front end: header state machine that classifies each input beat into queue entries.
module gzhs_front
    import gzhs_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    gzhs_in_if.sink      in_stream,
    input  logic         q_full,
    output logic         q_push,
    output cmd_t         q_cmd
);

    // Header parsing phases, one-hot.
    typedef enum logic [13:0] {
        PH_MAGIC0  = 14'h0001,
        PH_MAGIC1  = 14'h0002,
        PH_METHOD  = 14'h0004,
        PH_FLAGS   = 14'h0008,
        PH_FIXED   = 14'h0010,
        PH_XLEN_LO = 14'h0020,
        PH_XLEN_HI = 14'h0040,
        PH_XDATA   = 14'h0080,
        PH_NAME    = 14'h0100,
        PH_COMMENT = 14'h0200,
        PH_HCRC    = 14'h0400,
        PH_PAYLOAD = 14'h0800,
        PH_RAW     = 14'h1000,
        PH_DONE    = 14'h2000
    } phase_t;

    // Starting points for the search of the next optional header section.
    typedef enum logic [1:0] {
        FROM_XLEN    = 2'd0,
        FROM_NAME    = 2'd1,
        FROM_COMMENT = 2'd2
    } from_t;

    localparam logic [7:0] GZ_ID1          = 8'h1F;
    localparam logic [7:0] GZ_ID2          = 8'h8B;
    localparam logic [7:0] GZ_CM_DEFLATE   = 8'h08;
    localparam logic [7:0] GZ_FLG_RESERVED = 8'hE0;
    localparam logic [7:0] GZ_FLG_HCRC     = 8'h02;
    localparam logic [7:0] GZ_FLG_EXTRA    = 8'h04;
    localparam logic [7:0] GZ_FLG_NAME     = 8'h08;
    localparam logic [7:0] GZ_FLG_COMMENT  = 8'h10;

    // Bit positions of the stored flags.
    localparam int FB_HCRC    = 0;
    localparam int FB_EXTRA   = 1;
    localparam int FB_NAME    = 2;
    localparam int FB_COMMENT = 3;

    phase_t      phase_reg, phase_next;
    logic [7:0]  held_reg, held_next;
    logic [3:0]  flags_reg, flags_next;
    logic [15:0] skip_reg, skip_next;
    logic        wrapped_reg, wrapped_next;

    logic        accept;
    logic [7:0]  b;
    logic        eos;
    logic [15:0] skip_dec;
    logic [15:0] xlen;
    logic        push;
    logic        two;
    kind_t       k0, k1;
    logic [7:0]  b0, b1;

    // Picks the next present header section at or after the given one.
    function automatic phase_t advance(input from_t from, input logic [3:0] flags);
        phase_t ph;
        priority if (from == FROM_XLEN && flags[FB_EXTRA]) begin
            ph = PH_XLEN_LO;
        end
        else if ((from == FROM_XLEN || from == FROM_NAME) && flags[FB_NAME]) begin
            ph = PH_NAME;
        end
        else if (flags[FB_COMMENT]) begin
            ph = PH_COMMENT;
        end
        else if (flags[FB_HCRC]) begin
            ph = PH_HCRC;
        end
        else begin
            ph = PH_PAYLOAD;
        end
        return ph;
    endfunction

    assign in_stream.ready = !q_full;
    assign accept   = in_stream.valid && !q_full;
    assign b        = in_stream.data_byte;
    assign eos      = in_stream.end_of_stream;
    assign skip_dec = skip_reg - 16'd1;
    assign xlen     = {b, skip_reg[7:0]};

    // Classification of the accepted beat and the next header state.
    always_comb
    begin
        phase_next   = phase_reg;
        held_next    = held_reg;
        flags_next   = flags_reg;
        skip_next    = skip_reg;
        wrapped_next = wrapped_reg;
        push = 1'b0;
        two  = 1'b0;
        k0   = KIND_HEADER;
        k1   = KIND_HEADER;
        b0   = 8'd0;
        b1   = 8'd0;
        if (accept)
        begin
            unique case (phase_reg)
                PH_MAGIC0:
                begin
                    push = 1'b1;
                    if (eos)
                    begin
                        k0 = KIND_END;
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        held_next  = b;
                        phase_next = PH_MAGIC1;
                    end
                end
                PH_MAGIC1:
                begin
                    push = 1'b1;
                    if (eos)
                    begin
                        two = 1'b1;
                        k0  = KIND_PAYLOAD;
                        b0  = held_reg;
                        k1  = KIND_END;
                        phase_next = PH_DONE;
                    end
                    else if (held_reg == GZ_ID1 && b == GZ_ID2)
                    begin
                        wrapped_next = 1'b1;
                        phase_next   = PH_METHOD;
                    end
                    else
                    begin
                        // No gzip magic: replay the held byte ahead of this one.
                        two = 1'b1;
                        k0  = KIND_PAYLOAD;
                        b0  = held_reg;
                        k1  = KIND_PAYLOAD;
                        b1  = b;
                        phase_next = PH_RAW;
                    end
                end
                PH_PAYLOAD, PH_RAW:
                begin
                    push = 1'b1;
                    if (eos)
                    begin
                        k0 = KIND_END;
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        k0 = KIND_PAYLOAD;
                        b0 = b;
                    end
                end
                PH_METHOD, PH_FLAGS, PH_FIXED, PH_XLEN_LO, PH_XLEN_HI, PH_XDATA,
                PH_NAME, PH_COMMENT, PH_HCRC:
                begin
                    push = 1'b1;
                    if (eos)
                    begin
                        k0 = KIND_TRUNC;
                        phase_next = PH_DONE;
                    end
                    else if (phase_reg == PH_FLAGS &&
                             (held_reg != GZ_CM_DEFLATE || (b & GZ_FLG_RESERVED) != 8'd0))
                    begin
                        k0 = KIND_BAD;
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        unique case (phase_reg)
                            PH_METHOD:
                            begin
                                held_next  = b;
                                phase_next = PH_FLAGS;
                            end
                            PH_FLAGS:
                            begin
                                flags_next[FB_HCRC]    = (b & GZ_FLG_HCRC) != 8'd0;
                                flags_next[FB_EXTRA]   = (b & GZ_FLG_EXTRA) != 8'd0;
                                flags_next[FB_NAME]    = (b & GZ_FLG_NAME) != 8'd0;
                                flags_next[FB_COMMENT] = (b & GZ_FLG_COMMENT) != 8'd0;
                                skip_next  = 16'd6;
                                phase_next = PH_FIXED;
                            end
                            PH_FIXED:
                            begin
                                skip_next = skip_dec;
                                if (skip_dec == 16'd0)
                                begin
                                    phase_next = advance(FROM_XLEN, flags_reg);
                                end
                            end
                            PH_XLEN_LO:
                            begin
                                skip_next  = {8'd0, b};
                                phase_next = PH_XLEN_HI;
                            end
                            PH_XLEN_HI:
                            begin
                                skip_next = xlen;
                                if (xlen == 16'd0)
                                begin
                                    phase_next = advance(FROM_NAME, flags_reg);
                                end
                                else
                                begin
                                    phase_next = PH_XDATA;
                                end
                            end
                            PH_XDATA:
                            begin
                                skip_next = skip_dec;
                                if (skip_dec == 16'd0)
                                begin
                                    phase_next = advance(FROM_NAME, flags_reg);
                                end
                            end
                            PH_NAME:
                            begin
                                if (b == 8'd0)
                                begin
                                    phase_next = advance(FROM_COMMENT, flags_reg);
                                end
                            end
                            PH_COMMENT:
                            begin
                                if (b == 8'd0)
                                begin
                                    phase_next = flags_reg[FB_HCRC] ? PH_HCRC : PH_PAYLOAD;
                                end
                            end
                            PH_HCRC:
                            begin
                                skip_next = skip_dec;
                                if (skip_dec == 16'd0)
                                begin
                                    phase_next = PH_PAYLOAD;
                                end
                            end
                            default:
                            begin
                                phase_next = PH_DONE;
                            end
                        endcase
                    end
                end
                PH_DONE:
                begin
                    phase_next = PH_DONE;
                end
                default:
                begin
                    phase_next = PH_DONE;
                end
            endcase
            // Entering the header CRC loads its two-byte count.
            if (phase_next == PH_HCRC && phase_reg != PH_HCRC)
            begin
                skip_next = 16'd2;
            end
        end
    end

    // Queue entry for this beat.
    always_comb
    begin
        q_push = push;
        q_cmd.two                 = two;
        q_cmd.first.kind          = k0;
        q_cmd.first.payload_byte  = b0;
        q_cmd.first.wrapped       = wrapped_next;
        q_cmd.first.last          = !two;
        q_cmd.second.kind         = k1;
        q_cmd.second.payload_byte = b1;
        q_cmd.second.wrapped      = wrapped_next;
        q_cmd.second.last         = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_MAGIC0;
            held_reg    <= 8'd0;
            flags_reg   <= 4'd0;
            skip_reg    <= 16'd0;
            wrapped_reg <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            held_reg    <= held_next;
            flags_reg   <= flags_next;
            skip_reg    <= skip_next;
            wrapped_reg <= wrapped_next;
        end
    end

`ifndef ASSERT_OFF
    // Once the stream is finished the parser never leaves the final phase.
    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DONE |=> phase_reg == PH_DONE)
        else $error("parser left the final phase");

    // A two-beat entry only arises from the second stream byte.
    a_two_from_magic: assert property (@(posedge clk) disable iff (!rst_n)
        q_push && q_cmd.two |-> phase_reg == PH_MAGIC1 && !wrapped_next)
        else $error("two-beat entry outside magic check");
`endif

endmodule

>>> rtl/gzhs_queue.sv
// Short queue of classified entries between the front end and the result serializer.
module gzhs_queue
    import gzhs_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output logic full,
    output logic not_empty,
    output cmd_t head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    cmd_t          mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign full      = count_reg == FULL_CNT;
    assign not_empty = count_reg != '0;
    assign head      = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

`ifndef ASSERT_OFF
    // The front end never pushes into a full queue.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into full queue");
`endif

endmodule

>>> rtl/gzhs_back.sv
// Back end: turns queue entries into single result beats behind an output register.
module gzhs_back
    import gzhs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_valid,
    input  cmd_t       q_head,
    output logic       q_pop,
    gzhs_out_if.source out_stream
);

    logic    out_valid_reg, out_valid_next;
    result_t out_reg, out_next;
    logic    pend_valid_reg, pend_valid_next;
    result_t pend_reg, pend_next;
    logic    advance_out;

    assign advance_out = !out_valid_reg || out_stream.ready;
    assign q_pop       = advance_out && !pend_valid_reg && q_valid;

    // Load the output register from the pending second beat first, else from the queue.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        if (advance_out)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_next        = pend_reg;
                pend_valid_next = 1'b0;
            end
            else if (q_valid)
            begin
                out_valid_next  = 1'b1;
                out_next        = q_head.first;
                pend_next       = q_head.second;
                pend_valid_next = q_head.two;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        pend_reg <= pend_next;
    end

    assign out_stream.valid        = out_valid_reg;
    assign out_stream.kind         = out_reg.kind;
    assign out_stream.payload_byte = out_reg.payload_byte;
    assign out_stream.wrapped      = out_reg.wrapped;
    assign out_stream.last         = out_reg.last;

`ifndef ASSERT_OFF
    // A pending second beat always sits behind a valid, unmarked first beat.
    a_pend_behind_first: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> out_valid_reg && !out_reg.last)
        else $error("second beat pending without its first beat");
`endif

endmodule

>>> rtl/gzip_header_stripper.sv
// Top level of the gzip header stripper: front end, entry queue and result serializer.
// The block takes one stream byte per cycle while the entry queue has room and gives one result
// beat per cycle while the output is ready. Each byte yields one result, except the second
// byte of a stream that turns out not to be gzip (and an end right after the first byte), which
// yields two; the result serializer in the back end sends them in turn, and the entry queue of
// QUEUE_DEPTH entries (at least 2) absorbs the extra beat and output stalls. A byte's first
// result passes through the entry queue and then the output register. After a bad header, a
// truncated header or the end marker, further bytes are taken and give no results until reset.
module gzip_header_stripper
    import gzhs_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    gzhs_in_if.sink    in_stream,
    gzhs_out_if.source out_stream
);

    logic q_push, q_full, q_pop, q_valid;
    cmd_t q_cmd, q_head;

    gzhs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_stream (in_stream),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (q_cmd)
    );

    gzhs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_cmd  (q_cmd),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_valid),
        .head      (q_head)
    );

    gzhs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .out_stream (out_stream)
    );

endmodule
